// ===== hdl/lld_pkg.sv =====
package lld_pkg;
   localparam logic [1:0] FUNC_REQ    = 2'd0;
   localparam logic [1:0] FUNC_FB     = 2'd1;
   localparam logic [1:0] FUNC_STATUS = 2'd2;
   localparam logic [1:0] FUNC_NOP    = 2'd3;
   localparam logic [1:0] RC_OK       = 2'd0;
   localparam logic [1:0] RC_WARMUP   = 2'd1;
   localparam logic [1:0] RC_NONE     = 2'd2;
   localparam logic [1:0] RC_FAIL     = 2'd3;
   localparam logic [3:0] WARMUP_LIMIT = 4'd10;
   localparam int REQ_BYTES = 4;
   localparam int RSP_BYTES = 2;
   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_COUNT = 1'b1;
   typedef logic [REQ_BYTES*8-1:0] req_data_type;
   typedef logic [RSP_BYTES*8-1:0] rsp_data_type;
endpackage

// ===== hdl/least_loaded_dispatcher_unit.sv =====
// Status write, func 3 and feedback without rescan pass decode and output to the result beat;
// a rescan walks one slot per cycle through a shared load comparator.
// Least-loaded request: a send try plus a scan, once more for each closed slot picked;
// feedback with rescan: decode, scan, output; round robin: walks slots from the next pointer.
// One item at a time; a new beat is taken once the result register is free.
// Synchronous active-high reset: present/traffic set, loads cleared, mode 1, 8 slots.
module least_loaded_dispatcher_unit #(
   parameter int NSLOTS    = 8,
   parameter int LOAD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // slot[2:0], reported_load[18:3], closed_mask[26:19],
   // present[27], new[28], exited[29], traffic[30]
   input  lld_pkg::req_data_type         req_tdata,
   input  logic [1:0]                    req_tuser, // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // chosen_slot[2:0], result_code[4:3], live_slots[8:5]
   output lld_pkg::rsp_data_type         rsp_tdata,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [3:0]                    csr_wdata
);
   import lld_pkg::*;
   localparam int SB = $clog2(NSLOTS);
   localparam int CB = $clog2(NSLOTS + 1);
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEC  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_TRY  = 3'd3;
   localparam logic [2:0] ST_RR   = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]             state_ff;
   logic                   mode_ff;
   logic [3:0]             count_ff;
   logic [LOAD_BITS-1:0]   load_ff [NSLOTS];
   logic [NSLOTS-1:0]      pres_ff, new_ff, exd_ff, exg_ff, trf_ff;
   logic [SB-1:0]          cur_ff;
   logic [LOAD_BITS-1:0]   min_ff;
   logic [CB-1:0]          live_ff;
   logic [SB-1:0]          rrn_ff;
   logic [3:0]             warm_ff;
   req_data_type           item_ff;
   logic [1:0]             func_ff;
   logic [SB:0]            idx_ff;
   logic [SB-1:0]          k_ff;
   logic [SB-1:0]          pick_ff;
   logic [CB-1:0]          cnt_ff;
   logic                   after_ff;
   logic                   rv_ff;
   logic [2:0]             rslot_ff;
   logic [1:0]             rcode_ff;

   logic [CB-1:0] n_eff;
   logic [1:0]    func;
   logic [2:0]    islot;
   logic [SB-1:0] sidx;
   logic          slot_ok;
   logic [7:0]    cmask;
   logic [SB:0]   rri;
   logic [SB-1:0] si, rs, rr_start;
   logic          elig;
   logic [15:0]   fbv;
   logic [LOAD_BITS-1:0] fb_sat;

   always_comb begin
      if (count_ff == 4'd0) n_eff = CB'(1);
      else if ({28'd0, count_ff} > NSLOTS) n_eff = CB'(NSLOTS);
      else n_eff = CB'(count_ff);
   end

   always_comb begin
      if (LOAD_BITS < 16 && fbv > 16'(LOAD_MAX)) fb_sat = LOAD_MAX;
      else fb_sat = LOAD_BITS'(fbv);
   end

   assign func     = func_ff;
   assign islot    = item_ff[2:0];
   assign sidx     = SB'(islot);
   assign slot_ok  = {29'd0, islot} < NSLOTS;
   assign cmask    = item_ff[26:19];
   assign fbv      = item_ff[18:3];
   assign si       = idx_ff[SB-1:0];
   assign rr_start = ((SB+1)'(rrn_ff) >= (SB+1)'(n_eff)) ? '0 : rrn_ff;
   assign rri   = (SB+1)'(rr_start) + (SB+1)'(k_ff) >= (SB+1)'(n_eff) ?
                  (SB+1)'(rr_start) + (SB+1)'(k_ff) - (SB+1)'(n_eff) :
                  (SB+1)'(rr_start) + (SB+1)'(k_ff);
   assign rs    = rri[SB-1:0];
   assign elig  = pres_ff[rs] && !new_ff[rs] && !exd_ff[rs] && !exg_ff[rs] && trf_ff[rs];

   assign req_tready = (state_ff == ST_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0,
      (live_ff > CB'(15)) ? 4'd15 : 4'(live_ff), rcode_ff, rslot_ff};

   function automatic logic closed(input logic [7:0] m, input logic [SB-1:0] s);
      if ({{(32-SB){1'b0}}, s} >= 8) return 1'b0;
      return m[3'(s)];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b1;
         count_ff <= 4'd8;
         for (int i = 0; i < NSLOTS; i++) load_ff[i] <= '0;
         pres_ff <= '1; new_ff <= '0; exd_ff <= '0; exg_ff <= '0; trf_ff <= '1;
         cur_ff  <= '0;
         min_ff  <= '0;
         live_ff <= (NSLOTS < 8) ? CB'(NSLOTS) : CB'(8);
         rrn_ff  <= '0;
         warm_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_MODE) mode_ff <= csr_wdata[0];
            else count_ff <= csr_wdata;
         end
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  item_ff  <= req_tdata;
                  func_ff  <= req_tuser;
                  state_ff <= ST_DEC;
               end
            end
            ST_DEC: begin
               rslot_ff <= 3'd0;
               idx_ff   <= '0; cnt_ff <= '0; pick_ff <= '0; k_ff <= '0;
               case (func)
                  FUNC_REQ: begin
                     if (mode_ff) begin
                        rcode_ff <= RC_OK;
                        state_ff <= ST_TRY;
                     end else begin
                        if (warm_ff < WARMUP_LIMIT) warm_ff <= warm_ff + 4'd1;
                        if (warm_ff + 4'd1 < WARMUP_LIMIT) begin
                           rcode_ff <= RC_WARMUP;
                           state_ff <= ST_OUT;
                        end else begin
                           state_ff <= ST_RR;
                        end
                     end
                  end
                  FUNC_FB: begin
                     rcode_ff <= RC_OK;
                     if (slot_ok) load_ff[sidx] <= fb_sat;
                     if (slot_ok && min_ff > fb_sat) begin
                        after_ff <= 1'b0;
                        state_ff <= ST_SCAN;
                     end else begin
                        state_ff <= ST_OUT;
                     end
                  end
                  FUNC_STATUS: begin
                     rcode_ff <= RC_OK;
                     state_ff <= ST_OUT;
                     if (slot_ok) begin
                        pres_ff[sidx] <= item_ff[27];
                        new_ff[sidx]  <= item_ff[28];
                        exd_ff[sidx]  <= item_ff[29];
                        trf_ff[sidx]  <= item_ff[30];
                        if (item_ff[28]) exg_ff[sidx] <= 1'b0;
                     end
                  end
                  default: begin
                     rcode_ff <= RC_OK;
                     state_ff <= ST_OUT;
                  end
               endcase
            end
            ST_TRY: begin
               idx_ff <= '0; cnt_ff <= '0; pick_ff <= '0;
               if (closed(cmask, cur_ff)) begin
                  exg_ff[cur_ff]  <= 1'b1;
                  load_ff[cur_ff] <= '0;
                  after_ff <= 1'b1;
               end else begin
                  if (load_ff[cur_ff] != LOAD_MAX) load_ff[cur_ff] <= load_ff[cur_ff] + 1'b1;
                  rslot_ff <= 3'(cur_ff);
                  after_ff <= 1'b0;
               end
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               if (idx_ff < (SB+1)'(n_eff)) begin
                  if (pres_ff[si]) begin
                     if (new_ff[si]) new_ff[si] <= 1'b0;
                     else if (!exd_ff[si] && !exg_ff[si]) begin
                        cnt_ff <= cnt_ff + 1'b1;
                        if (cnt_ff == '0 || load_ff[si] < load_ff[pick_ff]) pick_ff <= si;
                     end
                  end
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  live_ff <= cnt_ff;
                  cur_ff  <= pick_ff;
                  min_ff  <= load_ff[pick_ff];
                  if (after_ff) begin
                     if (cnt_ff == '0) begin
                        rcode_ff <= RC_NONE;
                        rslot_ff <= 3'd0;
                        state_ff <= ST_OUT;
                     end else begin
                        state_ff <= ST_TRY;
                     end
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_RR: begin
               if (elig) begin
                  rrn_ff   <= (rri + 1'b1 >= (SB+1)'(n_eff)) ? '0 : SB'(rri + 1'b1);
                  rslot_ff <= 3'(rs);
                  if (closed(cmask, rs)) begin
                     exg_ff[rs] <= 1'b1;
                     rcode_ff   <= RC_FAIL;
                  end else begin
                     rcode_ff   <= RC_OK;
                  end
                  state_ff <= ST_OUT;
               end else begin
                  if (pres_ff[rs] && new_ff[rs]) new_ff[rs] <= 1'b0;
                  if ((SB+1)'(k_ff) + 1'b1 >= (SB+1)'(n_eff)) begin
                     rcode_ff <= RC_NONE;
                     state_ff <= ST_OUT;
                  end else k_ff <= k_ff + 1'b1;
               end
            end
            ST_OUT: begin
               rv_ff    <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == ST_OUT) else $error("result without sequencer");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while waiting");
`endif
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
   import lld_pkg::*;

   localparam int NSL = 8;
   localparam logic [15:0] LOAD_MAX = 16'hFFFF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  slot;
      logic [15:0] load;
      logic [7:0]  closed;
      logic        present;
      logic        is_new;
      logic        exited;
      logic        traffic;
   } work_item_t;

   typedef struct packed {
      logic [3:0] live;
      logic [1:0] code;
      logic [2:0] slot;
   } dispatch_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   req_data_type req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   rsp_data_type rsp_tdata;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [3:0] csr_wdata = '0;

   least_loaded_dispatcher_unit dut (.*);

   always #2 clock = ~clock;

   // shadow state
   logic        mode_q;
   logic [3:0]  count_q;
   logic [15:0] loads [NSL];
   logic        pres [NSL];
   logic        newf [NSL];
   logic        exd [NSL];
   logic        exg [NSL];
   logic        trf [NSL];
   int          best_slot, min_load, live_cnt, rr_next, warm;

   work_item_t  pending_items[$];
   dispatch_t   expected_dispatches[$];
   int          errors = 0;
   int          cycles = 0;
   int          accepted = 0;

   function automatic int slots_in_use();
      if (count_q < 1) return 1;
      if (count_q > NSL) return NSL;
      return count_q;
   endfunction

   function automatic void find_least();
      int n, live, pick;
      n = slots_in_use();
      live = 0;
      pick = 0;
      for (int i = 0; i < n; i++) begin
         if (!pres[i]) continue;
         if (newf[i]) begin
            newf[i] = 1'b0;
            continue;
         end
         if (exd[i] || exg[i]) continue;
         live++;
         if (live == 1 || loads[i] < loads[pick]) pick = i;
      end
      live_cnt = live;
      best_slot = pick;
      min_load = loads[pick];
   endfunction

   function automatic dispatch_t make_disp(int s, logic [1:0] c);
      dispatch_t d;
      d.slot = s[2:0];
      d.code = c;
      d.live = (live_cnt > 15) ? 4'd15 : live_cnt[3:0];
      return d;
   endfunction

   function automatic dispatch_t dispatch_item(work_item_t it);
      int p, n, st, i;
      bit found;
      case (it.func)
         FUNC_REQ: begin
            if (mode_q) begin
               p = best_slot;
               while (it.closed[p]) begin
                  exg[p] = 1'b1;
                  loads[p] = '0;
                  find_least();
                  if (live_cnt == 0) return make_disp(0, RC_NONE);
                  p = best_slot;
               end
               if (loads[p] < LOAD_MAX) loads[p]++;
               find_least();
               return make_disp(p, RC_OK);
            end
            n = slots_in_use();
            found = 0;
            i = 0;
            if (warm < WARMUP_LIMIT) warm++;
            if (warm < WARMUP_LIMIT) return make_disp(0, RC_WARMUP);
            st = (rr_next < n) ? rr_next : 0;
            for (int k = 0; k < n; k++) begin
               i = st + k;
               if (i >= n) i -= n;
               if (!pres[i]) continue;
               if (newf[i]) begin
                  newf[i] = 1'b0;
                  continue;
               end
               if (exd[i] || exg[i] || !trf[i]) continue;
               found = 1;
               break;
            end
            if (!found) return make_disp(0, RC_NONE);
            rr_next = (i + 1 >= n) ? 0 : i + 1;
            if (it.closed[i]) begin
               exg[i] = 1'b1;
               return make_disp(i, RC_FAIL);
            end
            return make_disp(i, RC_OK);
         end
         FUNC_FB: begin
            loads[it.slot] = it.load;
            if (min_load > it.load) find_least();
         end
         FUNC_STATUS: begin
            pres[it.slot] = it.present;
            newf[it.slot] = it.is_new;
            exd[it.slot] = it.exited;
            trf[it.slot] = it.traffic;
            if (it.is_new) exg[it.slot] = 1'b0;
         end
         default: ;
      endcase
      return make_disp(0, RC_OK);
   endfunction

   function automatic void shadow_reset();
      mode_q = 1'b1;
      count_q = 4'd8;
      for (int i = 0; i < NSL; i++) begin
         loads[i] = '0;
         pres[i] = 1'b1;
         newf[i] = 1'b0;
         exd[i] = 1'b0;
         exg[i] = 1'b0;
         trf[i] = 1'b1;
      end
      best_slot = 0;
      min_load = 0;
      live_cnt = slots_in_use();
      rr_next = 0;
      warm = 0;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   work_item_t drv_item;
   int req_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accepted++;
            expected_dispatches.push_back(dispatch_item(drv_item));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0 || pending_items.size() == 0) begin
               if (req_gap > 0) req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else begin
               work_item_t it;
               it = pending_items.pop_front();
               drv_item <= it;
               req_tdata <= {1'b0, it.traffic, it.exited, it.is_new, it.present,
                             it.closed, it.load, it.slot};
               req_tuser <= it.func;
               req_tvalid <= 1'b1;
               req_gap <= gap_len();
            end
         end
      end
   end

   // monitor
   int rsp_gap = 0;
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            dispatch_t got, want;
            got = dispatch_t'(rsp_tdata[8:0]);
            if (expected_dispatches.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, 0);
            end else begin
               want = expected_dispatches.pop_front();
               if (got.slot !== want.slot) report_mismatch("chosen_slot", got.slot, want.slot);
               if (got.code !== want.code) report_mismatch("result_code", got.code, want.code);
               if (got.live !== want.live) report_mismatch("live_slots", got.live, want.live);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= gap_len();
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("least_loaded_dispatcher_unit regression: fail");
         $finish;
      end
   end

   function automatic work_item_t rand_item(int req_pct);
      work_item_t it;
      int r;
      it = work_item_t'({$urandom, 1'($urandom)});
      r = $urandom_range(0, 99);
      if (r < req_pct) begin
         it.func = FUNC_REQ;
         it.closed = ($urandom_range(0, 2) == 0) ? it.closed : 8'h00;
      end else if (r < req_pct + 15) begin
         it.func = FUNC_FB;
         if ($urandom_range(0, 2) != 0) it.load = 16'($urandom_range(0, 20));
      end else if (r < 97) begin
         it.func = FUNC_STATUS;
         if ($urandom_range(0, 1)) begin
            it.present = 1'b1;
            it.exited = 1'b0;
            it.traffic = 1'b1;
         end
      end else begin
         it.func = FUNC_NOP;
      end
      return it;
   endfunction

   task automatic csr_write(logic idx, logic [3:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MODE) mode_q = val[0];
      else count_q = val;
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid || expected_dispatches.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      work_item_t it;
      int modes [6] = '{1, 0, 1, 0, 1, 0};
      int counts [6] = '{8, 8, 1, 0, 15, 3};
      shadow_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and special cases under reset config
      it = '0;
      it.func = FUNC_FB; it.slot = 3'd7; it.load = 16'hFFFF; pending_items.push_back(it);
      it.func = FUNC_FB; it.slot = 3'd0; it.load = 16'hFFFE; pending_items.push_back(it);
      it = '0; it.func = FUNC_REQ; it.closed = 8'hFF; pending_items.push_back(it);
      it = '0; it.func = FUNC_STATUS; it.slot = 3'd2; it.present = 1; it.is_new = 1;
      it.traffic = 1; pending_items.push_back(it);
      it.slot = 3'd0; pending_items.push_back(it);
      it = '0; it.func = FUNC_REQ; it.closed = 8'h01; pending_items.push_back(it);
      it = '0; it.func = FUNC_REQ; pending_items.push_back(it);
      it = '0; it.func = FUNC_NOP; it.closed = 8'hAA; it.load = 16'h5555;
      pending_items.push_back(it);
      it = '0; it.func = FUNC_STATUS; it.slot = 3'd5; it.exited = 1; pending_items.push_back(it);
      it = '0; it.func = FUNC_FB; it.slot = 3'd4; it.load = 16'h0000; pending_items.push_back(it);
      it = '0; it.func = FUNC_REQ; it.closed = 8'h10; pending_items.push_back(it);
      drain();
      csr_write(CSR_MODE, 4'd0);
      for (int i = 0; i < 12; i++) begin
         it = '0; it.func = FUNC_REQ; it.closed = (i == 11) ? 8'hFF : 8'h00;
         pending_items.push_back(it);
      end
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_MODE, modes[ph][3:0]);
         csr_write(CSR_COUNT, counts[ph][3:0]);
         for (int i = 0; i < 105; i++) pending_items.push_back(rand_item(60));
         drain();
      end

      if (errors == 0) begin
         $display("least_loaded_dispatcher_unit regression: pass");
      end else begin
         $display("least_loaded_dispatcher_unit regression: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/lld_pkg.sv
hdl/least_loaded_dispatcher_unit.sv
verif/testbench.sv
